// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent checked on the same edge.
`define SBN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbn assertion failed");

// Consequent checked on the edge after the antecedent.
`define SBN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbn assertion failed");

`endif

// ===== sv/sbn_pkg.sv =====
// Types and constants for the slotted bus node exchange block.
// No dependencies; used by the top level and the checker.
`default_nettype none

package sbn_pkg;

    // Bus framing
    localparam int RX_SLOT_BYTES     = 2;   // command bytes per node slot
    localparam int LONG_FRAME_BYTES  = 6;
    localparam int SHORT_FRAME_BYTES = 3;
    localparam int FRAME_W           = 3;   // holds a frame size

    // Result slot: encoder reset or new reference, then up to a long frame
    localparam int RES_MAX   = 7;
    localparam int RES_CNT_W = $clog2(RES_MAX + 1);
    localparam int RES_IDX_W = $clog2(RES_MAX);

    // Upper bound on transmit phase moves for one item
    localparam int TX_PASSES = 8;

    // Widths
    localparam int NODE_W     = 5;
    localparam int CNT_W      = 8;
    localparam int CMP_W      = CNT_W + 1;  // byte-count compares and slot products
    localparam int RX_TMR_W   = 16;
    localparam int TX_TMR_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Register reset values
    localparam logic [NODE_W-1:0]   NODE_ID_RST = NODE_W'(1);
    localparam logic [TX_TMR_W-1:0] TIMEOUT_RST = TX_TMR_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID      = 3'd0,
        CFG_LAST_NODE_ID = 3'd1,
        CFG_START_LONG   = 3'd2,
        CFG_START_SHORT  = 3'd3,
        CFG_START_RESET  = 3'd4,
        CFG_RX_TIMEOUT   = 3'd5,
        CFG_TX_TIMEOUT   = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        RXP_WAIT = 2'd0,
        RXP_PROC = 2'd1,
        RXP_END  = 2'd2
    } rx_phase_t;

    typedef enum logic [1:0] {
        TXP_WAIT = 2'd0,
        TXP_SKIP = 2'd1,
        TXP_REST = 2'd2,
        TXP_END  = 2'd3
    } tx_phase_t;

    typedef enum logic [1:0] {
        KIND_TX_BYTE   = 2'd0,
        KIND_NEW_REF   = 2'd1,
        KIND_ENC_RESET = 2'd2
    } kind_t;

    typedef struct packed {
        logic               req_type;
        logic [7:0]         rx_byte;
        logic               tx_fifo_empty;
        logic               limit_left;
        logic               limit_right;
        logic [15:0]        encoder_count;
        logic signed [15:0] current_scaled;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        out_kind;
        logic [7:0]        out_byte;
        logic signed [7:0] ref_value;
        logic              last;
    } out_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_val;
        logic [7:0] ref_val;
    } res_entry_t;

endpackage

`default_nettype wire

// ===== sv/slotted_bus_node_exchange.sv =====
// Slotted bus node exchange: top level, the only RTL module of the block.
// Depends on sbn_pkg; assertions attach from sbn_checker.sv by bind.
`default_nettype none

// Node on a shared byte bus. Each input item is either a received bus byte or a
// one millisecond tick, together with a snapshot of the node's sensors. A start
// code opens a cycle; the node captures its own command slot, hands out a new
// current reference when reference and check byte agree, then counts the other
// nodes' reply bytes and emits its own reply frame (encoder and additive
// checksum, plus status and current in a long frame) when its slot comes up.
// Results leave as a burst of items on the out channel, last marking the final
// one of an input item; an input item that causes nothing produces no output.
// An accepted item waits in the input register until the result slot is free,
// is evaluated in a single pass, and its results are registered in the result
// slot. One item is accepted per clock as long as the result slot drains; an
// item's results (at most 7) hold the slot until taken, while the input register
// absorbs one further item. Configuration registers are written through the cfg
// channel, which is always ready, and must only change while the block is idle.
module slotted_bus_node_exchange (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sbn_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sbn_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbn_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sbn_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NODE_W-1:0]     node_id_reg;
    logic [NODE_W-1:0]     last_node_id_reg;
    logic [7:0]            start_long_reg;
    logic [7:0]            start_short_reg;
    logic [7:0]            start_reset_reg;
    logic [TX_TMR_W-1:0]   rx_timeout_reg;
    logic [TX_TMR_W-1:0]   tx_timeout_reg;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                  in_vld_reg, in_vld_next;
    in_item_t              in_item_reg;

    // ------------------------------------------------------------------
    // Protocol state
    // ------------------------------------------------------------------
    rx_phase_t             rx_phase_reg, rx_phase_next;
    tx_phase_t             tx_phase_reg, tx_phase_next;
    logic [CNT_W-1:0]      rx_byte_count_reg, rx_byte_count_next;
    logic [CNT_W-1:0]      reply_byte_count_reg, reply_byte_count_next;
    logic [RX_TMR_W-1:0]   rx_timer_reg, rx_timer_next;
    logic [TX_TMR_W-1:0]   tx_timer_reg, tx_timer_next;
    logic                  long_frame_reg, long_frame_next;
    logic                  reply_pending_reg, reply_pending_next;
    logic                  tx_finished_reg, tx_finished_next;
    logic [7:0]            captured_ref_reg, captured_ref_next;
    logic [7:0]            captured_check_reg, captured_check_next;

    // ------------------------------------------------------------------
    // Result slot: entries shift toward index 0 as they are taken
    // ------------------------------------------------------------------
    res_entry_t            res_reg [RES_MAX];
    res_entry_t            res_new [RES_MAX];
    logic [RES_CNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic [RES_CNT_W-1:0]  res_cnt_new;

    logic                  take;
    logic                  slot_free;
    logic                  proc;

    // What the evaluated item caused
    logic                  enc_hit;
    logic                  ref_hit;
    logic                  frame_hit;

    // Slot products, from configuration and the current frame length
    logic [CMP_W-1:0]      lp1;            // last_node_id + 1
    logic [CMP_W-1:0]      rx_end_mul;     // (last + 1) * slot bytes
    logic [CMP_W-1:0]      frame_end_mul;  // (last + 1) * current frame size
    logic [RX_TMR_W-1:0]   rx_wait_slot;
    logic [RX_TMR_W-1:0]   rx_wait_frame;
    logic [CMP_W-1:0]      rx_base;
    logic [CMP_W-1:0]      rx_done_cnt;

    assign cfg_ready = 1'b1;

    assign take      = out_valid && out_ready;
    assign slot_free = (res_cnt_reg == '0) ||
                       ((res_cnt_reg == RES_CNT_W'(1)) && out_ready);
    assign proc      = in_vld_reg && slot_free;
    assign in_ready  = !in_vld_reg || proc;

    assign out_valid          = (res_cnt_reg != '0);
    assign out_item.out_kind  = res_reg[0].kind;
    assign out_item.out_byte  = res_reg[0].byte_val;
    assign out_item.ref_value = res_reg[0].ref_val;
    assign out_item.last      = (res_cnt_reg == RES_CNT_W'(1));

    assign lp1           = CMP_W'(last_node_id_reg) + CMP_W'(1);
    assign rx_end_mul    = CMP_W'(lp1 * CMP_W'(RX_SLOT_BYTES));
    assign frame_end_mul = lp1 * (long_frame_reg ? CMP_W'(LONG_FRAME_BYTES)
                                                 : CMP_W'(SHORT_FRAME_BYTES));
    assign rx_wait_slot  = RX_TMR_W'(rx_timeout_reg) * RX_TMR_W'(rx_end_mul);
    assign rx_wait_frame = RX_TMR_W'(rx_timeout_reg) * RX_TMR_W'(frame_end_mul);
    assign rx_base       = CMP_W'(node_id_reg - NODE_W'(1)) * CMP_W'(RX_SLOT_BYTES);
    assign rx_done_cnt   = CMP_W'(last_node_id_reg) * CMP_W'(RX_SLOT_BYTES);

    assign in_vld_next = (in_valid && in_ready) ? 1'b1 : (proc ? 1'b0 : in_vld_reg);

    // ------------------------------------------------------------------
    // Next state: one pass over the receive side, then the transmit side
    // settles through its phases.
    // ------------------------------------------------------------------
    always_comb begin : step_logic
        logic                 have;
        logic                 tx_stop;
        logic                 moved;
        logic [7:0]           rx_b;
        logic [FRAME_W-1:0]   frame_v;
        logic [CMP_W-1:0]     tx_base;
        logic [CMP_W-1:0]     tx_end;
        logic [CMP_W-1:0]     rx_cnt_ext;

        rx_phase_next         = rx_phase_reg;
        tx_phase_next         = tx_phase_reg;
        rx_byte_count_next    = rx_byte_count_reg;
        reply_byte_count_next = reply_byte_count_reg;
        rx_timer_next         = rx_timer_reg;
        tx_timer_next         = tx_timer_reg;
        long_frame_next       = long_frame_reg;
        reply_pending_next    = reply_pending_reg;
        tx_finished_next      = tx_finished_reg;
        captured_ref_next     = captured_ref_reg;
        captured_check_next   = captured_check_reg;
        enc_hit               = 1'b0;
        ref_hit               = 1'b0;
        frame_hit             = 1'b0;
        have                  = 1'b0;
        tx_stop               = 1'b0;
        moved                 = 1'b0;
        rx_b                  = in_item_reg.rx_byte;
        frame_v               = FRAME_W'(SHORT_FRAME_BYTES);
        tx_base               = '0;
        tx_end                = '0;
        rx_cnt_ext            = '0;

        if (proc) begin
            have = !in_item_reg.req_type;

            // Tick: both timers count down, stopping at zero
            if (in_item_reg.req_type) begin
                if (rx_timer_next != '0) rx_timer_next = rx_timer_next - RX_TMR_W'(1);
                if (tx_timer_next != '0) tx_timer_next = tx_timer_next - TX_TMR_W'(1);
            end

            unique case (rx_phase_reg)
                RXP_WAIT: begin
                    if (have) begin
                        have = 1'b0;
                        // long code wins over short, short over reset
                        if (rx_b == start_long_reg) begin
                            rx_timer_next      = RX_TMR_W'(rx_timeout_reg);
                            rx_byte_count_next = '0;
                            long_frame_next    = 1'b1;
                            rx_phase_next      = RXP_PROC;
                        end else if (rx_b == start_short_reg) begin
                            rx_timer_next      = RX_TMR_W'(rx_timeout_reg);
                            rx_byte_count_next = '0;
                            long_frame_next    = 1'b0;
                            rx_phase_next      = RXP_PROC;
                        end else if (rx_b == start_reset_reg) begin
                            rx_timer_next      = RX_TMR_W'(rx_timeout_reg);
                            rx_byte_count_next = '0;
                            long_frame_next    = 1'b0;
                            rx_phase_next      = RXP_PROC;
                            enc_hit            = 1'b1;
                        end
                    end
                end
                RXP_PROC: begin
                    if (rx_timer_next == '0) begin
                        rx_phase_next = RXP_END;
                        rx_timer_next = rx_wait_slot;
                    end else if (have) begin
                        have = 1'b0;
                        if (node_id_reg != '0) begin
                            rx_cnt_ext = CMP_W'(rx_byte_count_next);
                            if (rx_cnt_ext == rx_base) begin
                                captured_ref_next = rx_b;
                            end else if (rx_cnt_ext == rx_base + CMP_W'(1)) begin
                                captured_check_next = rx_b;
                            end
                        end
                        rx_byte_count_next = rx_byte_count_next + CNT_W'(1);
                    end
                    // Command complete: arm the reply and the end wait
                    if (CMP_W'(rx_byte_count_next) == rx_done_cnt) begin
                        reply_pending_next = 1'b1;
                        rx_phase_next      = RXP_END;
                        rx_timer_next      = rx_wait_frame;
                        if (captured_ref_next == captured_check_next) ref_hit = 1'b1;
                    end
                end
                default: begin
                    // end phase: back to waiting once the reply is out or time is up
                    if (tx_finished_reg || (rx_timer_next == '0)) begin
                        tx_finished_next = 1'b0;
                        rx_phase_next    = RXP_WAIT;
                    end
                end
            endcase

            frame_v = long_frame_next ? FRAME_W'(LONG_FRAME_BYTES)
                                      : FRAME_W'(SHORT_FRAME_BYTES);
            tx_base = CMP_W'(node_id_reg - NODE_W'(1)) * CMP_W'(frame_v);
            tx_end  = lp1 * CMP_W'(frame_v);

            for (int it = 0; it < TX_PASSES; it++) begin
                if (!tx_stop) begin
                    moved = 1'b0;
                    unique case (tx_phase_next)
                        TXP_WAIT: begin
                            if (reply_pending_next) begin
                                reply_pending_next    = 1'b0;
                                reply_byte_count_next = '0;
                                tx_timer_next         = tx_timeout_reg;
                                tx_phase_next         = TXP_SKIP;
                                moved                 = 1'b1;
                            end
                        end
                        TXP_SKIP: begin
                            if (tx_timer_next == '0) begin
                                tx_phase_next = TXP_END;
                                moved         = 1'b1;
                            end else if ((node_id_reg != '0) &&
                                         (CMP_W'(reply_byte_count_next) == tx_base)) begin
                                frame_hit             = 1'b1;
                                reply_byte_count_next = reply_byte_count_next +
                                                        CNT_W'(frame_v);
                                tx_phase_next         = TXP_REST;
                                moved                 = 1'b1;
                            end else if (have) begin
                                have                  = 1'b0;
                                tx_timer_next         = tx_timeout_reg;
                                reply_byte_count_next = reply_byte_count_next + CNT_W'(1);
                                moved                 = 1'b1;
                            end
                        end
                        TXP_REST: begin
                            if ((tx_timer_next == '0) ||
                                (CMP_W'(reply_byte_count_next) == tx_end)) begin
                                tx_phase_next = TXP_END;
                                moved         = 1'b1;
                            end else if (have) begin
                                have                  = 1'b0;
                                reply_byte_count_next = reply_byte_count_next + CNT_W'(1);
                                moved                 = 1'b1;
                            end
                        end
                        TXP_END: begin
                            // returning to wait ends the settling for this item
                            if (in_item_reg.tx_fifo_empty) begin
                                tx_phase_next    = TXP_WAIT;
                                tx_finished_next = 1'b1;
                            end
                        end
                    endcase
                    if (!moved) tx_stop = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result list for the evaluated item, in order of occurrence
    // ------------------------------------------------------------------
    always_comb begin : result_build
        logic [7:0]           fb [LONG_FRAME_BYTES];
        logic [FRAME_W-1:0]   fcnt;
        logic [15:0]          enc;
        logic [15:0]          cur;

        res_new     = '{default: '0};
        res_cnt_new = '0;
        enc         = in_item_reg.encoder_count;
        cur         = in_item_reg.current_scaled;
        fb          = '{default: '0};

        if (long_frame_next) begin
            fcnt  = FRAME_W'(LONG_FRAME_BYTES);
            fb[0] = {6'b0, in_item_reg.limit_right, in_item_reg.limit_left};
            fb[1] = enc[7:0];
            fb[2] = enc[15:8];
            fb[3] = cur[7:0];
            fb[4] = cur[15:8];
            fb[5] = fb[0] + fb[1] + fb[2] + fb[3] + fb[4];
        end else begin
            fcnt  = FRAME_W'(SHORT_FRAME_BYTES);
            fb[0] = enc[7:0];
            fb[1] = enc[15:8];
            fb[2] = fb[0] + fb[1];
        end

        if (enc_hit) begin
            res_new[res_cnt_new[RES_IDX_W-1:0]] = '{kind: KIND_ENC_RESET,
                                                   byte_val: 8'd0, ref_val: 8'd0};
            res_cnt_new = res_cnt_new + RES_CNT_W'(1);
        end
        if (ref_hit) begin
            res_new[res_cnt_new[RES_IDX_W-1:0]] = '{kind: KIND_NEW_REF,
                                                   byte_val: 8'd0,
                                                   ref_val: captured_ref_next};
            res_cnt_new = res_cnt_new + RES_CNT_W'(1);
        end
        if (frame_hit) begin
            for (int k = 0; k < LONG_FRAME_BYTES; k++) begin
                if (FRAME_W'(k) < fcnt) begin
                    res_new[res_cnt_new[RES_IDX_W-1:0]] = '{kind: KIND_TX_BYTE,
                                                           byte_val: fb[k],
                                                           ref_val: 8'd0};
                    res_cnt_new = res_cnt_new + RES_CNT_W'(1);
                end
            end
        end
    end

    always_comb begin : slot_count
        if (proc && (res_cnt_new != '0)) begin
            res_cnt_next = res_cnt_new;
        end else if (take) begin
            res_cnt_next = res_cnt_reg - RES_CNT_W'(1);
        end else begin
            res_cnt_next = res_cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            node_id_reg          <= NODE_ID_RST;
            last_node_id_reg     <= NODE_ID_RST;
            start_long_reg       <= '0;
            start_short_reg      <= '0;
            start_reset_reg      <= '0;
            rx_timeout_reg       <= TIMEOUT_RST;
            tx_timeout_reg       <= TIMEOUT_RST;
            in_vld_reg           <= 1'b0;
            rx_phase_reg         <= RXP_WAIT;
            tx_phase_reg         <= TXP_WAIT;
            rx_byte_count_reg    <= '0;
            reply_byte_count_reg <= '0;
            rx_timer_reg         <= '0;
            tx_timer_reg         <= '0;
            long_frame_reg       <= 1'b0;
            reply_pending_reg    <= 1'b0;
            tx_finished_reg      <= 1'b0;
            captured_ref_reg     <= '0;
            captured_check_reg   <= '0;
            res_cnt_reg          <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_NODE_ID:      node_id_reg      <= cfg_data[NODE_W-1:0];
                    CFG_LAST_NODE_ID: last_node_id_reg <= cfg_data[NODE_W-1:0];
                    CFG_START_LONG:   start_long_reg   <= cfg_data;
                    CFG_START_SHORT:  start_short_reg  <= cfg_data;
                    CFG_START_RESET:  start_reset_reg  <= cfg_data;
                    CFG_RX_TIMEOUT:   rx_timeout_reg   <= cfg_data;
                    CFG_TX_TIMEOUT:   tx_timeout_reg   <= cfg_data;
                    default: ;  // index beyond the register list is ignored
                endcase
            end
            in_vld_reg           <= in_vld_next;
            rx_phase_reg         <= rx_phase_next;
            tx_phase_reg         <= tx_phase_next;
            rx_byte_count_reg    <= rx_byte_count_next;
            reply_byte_count_reg <= reply_byte_count_next;
            rx_timer_reg         <= rx_timer_next;
            tx_timer_reg         <= tx_timer_next;
            long_frame_reg       <= long_frame_next;
            reply_pending_reg    <= reply_pending_next;
            tx_finished_reg      <= tx_finished_next;
            captured_ref_reg     <= captured_ref_next;
            captured_check_reg   <= captured_check_next;
            res_cnt_reg          <= res_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            in_item_reg <= in_item;
        end
        if (proc && (res_cnt_new != '0)) begin
            res_reg <= res_new;
        end else if (take) begin
            for (int k = 0; k < RES_MAX - 1; k++) begin
                res_reg[k] <= res_reg[k + 1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/sbn_checker.sv =====
// Port-level checker for the slotted bus node exchange, bound to the top level.
// Depends on sbn_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sbn_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  sbn_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready
);

    // stalled result holds
    `SBN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

    // a burst continues without a gap until its last item
    `SBN_ASSERT_NEXT(a_burst_cont, out_valid && out_ready && !out_item.last, out_valid)

    // input only stalls behind pending results
    `SBN_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !(out_ready && out_item.last))

    // configuration is never back-pressured
    `SBN_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind slotted_bus_node_exchange sbn_checker u_sbn_checker (.*);

`default_nettype wire
